// ===== hw/rtl/mtf_pkg.sv =====
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared constants and types of the move-to-front codec: operation and status
// codes, and the control and result groups between sequencer and cell row.
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int ALPHABET_SIZE_DEF = 256;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_DECLARE = 2'd1;
    localparam logic [1:0] OP_CODE    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_BAD_IDX = 2'd2;

    localparam logic [7:0] SENTINEL   = 8'd0;

    typedef struct packed {
        logic       push;
        logic       code;
        logic       decode;
        logic [7:0] key;
    } t_chain_ctrl;

    typedef struct packed {
        logic       hit;
        logic [7:0] pos;
        logic [7:0] front;
    } t_chain_res;

endpackage

// ===== hw/rtl/mtf_cell.sv =====
// ----------------------------------------------------------------------------
// mtf_cell
// One table entry: holds a symbol, compares it with the key, and takes its
// neighbor's symbol when the row shifts down.
// ----------------------------------------------------------------------------
module mtf_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_prev_sym,
    input  logic [7:0] i_key,
    output logic [7:0] o_sym,
    output logic       o_hit
);

    logic [7:0] r_sym;
    logic [7:0] n_sym;

    assign n_sym = i_shift ? i_prev_sym : r_sym;

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
    end

    assign o_sym = r_sym;
    assign o_hit = (r_sym == i_key);

endmodule

// ===== hw/rtl/mtf_chain.sv =====
// ----------------------------------------------------------------------------
// mtf_chain
// Row of symbol cells with match selection, suffix-or shift mask and head
// data; does a push to front or one move-to-front step per cycle.
// ----------------------------------------------------------------------------
module mtf_chain
    import mtf_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    localparam int IW = $clog2(ALPHABET_SIZE),
    localparam int CW = $clog2(ALPHABET_SIZE + 1),
    localparam int LV = $clog2(ALPHABET_SIZE)
) (
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    input  logic [CW-1:0] i_count,
    output t_chain_res  o_res
);

    logic [7:0] w_sym [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] w_hit;
    logic [ALPHABET_SIZE-1:0] w_sel;
    logic [ALPHABET_SIZE-1:0] w_suf [LV+1];
    logic [ALPHABET_SIZE-1:0] w_shift;
    logic [7:0] w_head;
    logic [7:0] w_sel_sym;
    logic [IW-1:0] w_pos;
    logic [8:0] w_key9;
    logic [8:0] w_cnt9;

    assign w_key9 = {1'b0, i_ctrl.key};
    assign w_cnt9 = 9'(i_count);

    always_comb begin
        for (int k = 0; k < ALPHABET_SIZE; k++) begin
            if (i_ctrl.decode) begin
                w_sel[k] = (9'(k) == w_key9) && (w_key9 < w_cnt9);
            end else begin
                w_sel[k] = w_hit[k] && (9'(k) < w_cnt9);
            end
        end
    end

    assign w_suf[0] = w_sel;

    genvar l, k;
    generate
        for (l = 0; l < LV; l++) begin : g_lvl
            for (k = 0; k < ALPHABET_SIZE; k++) begin : g_bit
                if (k + (1 << l) < ALPHABET_SIZE) begin : g_or
                    assign w_suf[l+1][k] = w_suf[l][k] | w_suf[l][k + (1 << l)];
                end else begin : g_pass
                    assign w_suf[l+1][k] = w_suf[l][k];
                end
            end
        end
    endgenerate

    always_comb begin
        w_sel_sym = '0;
        w_pos     = '0;
        for (int j = 0; j < ALPHABET_SIZE; j++) begin
            w_sel_sym = w_sel_sym | (w_sel[j] ? w_sym[j] : 8'd0);
            w_pos     = w_pos | (w_sel[j] ? IW'(j) : '0);
        end
    end

    assign w_head  = i_ctrl.push ? i_ctrl.key : w_sel_sym;
    assign w_shift = i_ctrl.push ? '1 : (i_ctrl.code ? w_suf[LV] : '0);

    generate
        for (k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
            mtf_cell u_cell (
                .i_clk      (i_clk),
                .i_shift    (w_shift[k]),
                .i_prev_sym ((k == 0) ? w_head : w_sym[(k == 0) ? 0 : k - 1]),
                .i_key      (i_ctrl.key),
                .o_sym      (w_sym[k]),
                .o_hit      (w_hit[k])
            );
        end
    endgenerate

    assign o_res.hit   = |w_sel;
    assign o_res.pos   = 8'(w_pos);
    assign o_res.front = w_sel_sym;

endmodule

// ===== hw/rtl/move_to_front_codec_unit.sv =====
// ----------------------------------------------------------------------------
// move_to_front_codec_unit
// Byte move-to-front encoder and decoder over a row of symbol cells, with
// presence map, table build sweep and a registered result.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_operation, i_value
//   result    out        o_valid / i_stall    o_coded, o_status
//   config    in         psel/penable/pready  paddr, pwdata, prdata
//
// a code transaction on a built table codes in the cycle it is accepted and its
// result is offered from the next cycle on. the first code transaction after
// reset, a clear or a declaration that sets a presence bit pushes the sentinel,
// sweeps the presence map from ALPHABET_SIZE - 1 down to 1, then codes. input
// stalls during the sweep and the code step, and while a result waits.
// synchronous active-low reset clears presence map, count, build flag, mode.
// ----------------------------------------------------------------------------
module move_to_front_codec_unit
    import mtf_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_coded,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(ALPHABET_SIZE);
    localparam int CW = $clog2(ALPHABET_SIZE + 1);
    localparam logic [8:0] ASIZE9 = 9'(ALPHABET_SIZE);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_BUILD = 3'b010,
        S_CODE  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [ALPHABET_SIZE-1:0] r_present, n_present;
    logic [CW-1:0] r_count, n_count;
    logic r_built, n_built;
    logic r_mode;
    logic [IW-1:0] r_sym, n_sym;
    logic [7:0] r_val, n_val;
    logic r_out_valid, n_out_valid;
    logic [7:0] r_coded, n_coded;
    logic [1:0] r_status, n_status;

    t_chain_ctrl w_ctrl;
    t_chain_res  w_res;
    logic w_accept;
    logic w_out_busy;
    logic w_emit;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_mode} : 32'd0;

    assign w_out_busy = r_out_valid && i_stall;
    assign o_stall    = (r_state != S_IDLE) || w_out_busy;
    assign w_accept   = i_valid && !o_stall;

    always_comb begin
        n_state   = r_state;
        n_present = r_present;
        n_count   = r_count;
        n_built   = r_built;
        n_sym     = r_sym;
        n_val     = r_val;
        w_ctrl    = '{push: 1'b0, code: 1'b0, decode: r_mode, key: i_value};
        w_emit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_operation == OP_CLEAR) begin
                        n_present = '0;
                        n_count   = '0;
                        n_built   = 1'b0;
                    end else if (i_operation == OP_DECLARE) begin
                        if (i_value != SENTINEL && {1'b0, i_value} < ASIZE9) begin
                            n_present[i_value[IW-1:0]] = 1'b1;
                            n_built = 1'b0;
                        end
                    end else if (i_operation == OP_CODE) begin
                        if (r_built) begin
                            w_ctrl.code = 1'b1;
                            w_emit      = 1'b1;
                        end else begin
                            w_ctrl.push = 1'b1;
                            w_ctrl.key  = SENTINEL;
                            n_count     = CW'(1);
                            n_sym       = IW'(ALPHABET_SIZE - 1);
                            n_val       = i_value;
                            n_state     = S_BUILD;
                        end
                    end
                end
            end
            S_BUILD: begin
                w_ctrl.key = 8'(r_sym);
                if (r_present[r_sym]) begin
                    w_ctrl.push = 1'b1;
                    n_count     = r_count + CW'(1);
                end
                if (r_sym == IW'(1)) begin
                    n_built = 1'b1;
                    n_state = S_CODE;
                end else begin
                    n_sym = r_sym - IW'(1);
                end
            end
            S_CODE: begin
                w_ctrl.key = r_val;
                if (!w_out_busy) begin
                    w_ctrl.code = 1'b1;
                    w_emit      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        n_coded     = r_coded;
        n_status    = r_status;
        if (w_emit) begin
            n_out_valid = 1'b1;
            if (w_res.hit) begin
                n_coded  = r_mode ? w_res.front : w_res.pos;
                n_status = ST_OK;
            end else begin
                n_coded  = 8'd0;
                n_status = r_mode ? ST_BAD_IDX : ST_ABSENT;
            end
        end
    end

    mtf_chain #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_count (r_count),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= '0;
            r_count     <= '0;
            r_built     <= 1'b0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_count     <= n_count;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
                r_mode <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym    <= n_sym;
        r_val    <= n_val;
        r_coded  <= n_coded;
        r_status <= n_status;
    end

    assign o_valid  = r_out_valid;
    assign o_coded  = r_coded;
    assign o_status = r_status;

endmodule
